FILE: sv/sst_pkg.sv
// Shared types and constants for the subscription set table.
package sst_pkg;

    localparam int SLOT_COUNT_DEF = 32;
    localparam int TOPIC_BITS_DEF = 16;
    localparam int TOPIC_IN_W     = 16;
    localparam int FUNC_W         = 2;
    localparam int STATUS_W       = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_DELETE = 2'd1,
        FN_FIND   = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

FILE: sv/sst_mem.sv
// Slot memory: one write port, one read port with registered read data.
module sst_mem
    import sst_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int TOPIC_BITS = TOPIC_BITS_DEF,
    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
)
(
    input  logic                  clk,
    input  mem_ctl_t              ctl,
    input  logic [AW-1:0]         wr_addr,
    input  logic [TOPIC_BITS-1:0] wr_data,
    input  logic [AW-1:0]         rd_addr,
    output logic [TOPIC_BITS-1:0] rd_data
);

    logic [TOPIC_BITS-1:0] slots_reg [SLOT_COUNT];
    logic [TOPIC_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            slots_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= slots_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/sst_ctrl.sv
// Request sequencer: clearing pass, slot scan, decision and write-back.
module sst_ctrl
    import sst_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int TOPIC_BITS = TOPIC_BITS_DEF,
    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [FUNC_W-1:0]     func,
    input  logic [TOPIC_IN_W-1:0] topic,
    output logic                  busy,
    output logic                  done,
    output logic [STATUS_W-1:0]   status,
    output mem_ctl_t              mem_ctl,
    output logic [AW-1:0]         wr_addr,
    output logic [TOPIC_BITS-1:0] wr_data,
    output logic [AW-1:0]         rd_addr,
    input  logic [TOPIC_BITS-1:0] rd_data
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    localparam logic [TOPIC_BITS-1:0] EMPTY    = '1;
    localparam logic [AW-1:0]         LAST_IDX = AW'(SLOT_COUNT - 1);

    state_t                state_reg;
    logic [AW-1:0]         idx_reg;
    logic [AW-1:0]         hit_idx_reg;
    logic                  hit_reg;
    logic [AW-1:0]         empty_idx_reg;
    logic                  empty_reg;
    func_t                 func_reg;
    logic [TOPIC_BITS-1:0] key_reg;
    logic                  done_reg;
    status_t               status_reg;

    logic                  accept;
    logic                  reserved;
    logic                  do_write;
    logic [AW-1:0]         slot_addr;
    logic [TOPIC_BITS-1:0] slot_data;
    status_t               status_next;

    assign accept   = start && (state_reg == S_IDLE);
    assign reserved = (key_reg == EMPTY);

    always_comb
    begin
        do_write    = 1'b0;
        slot_addr   = hit_idx_reg;
        slot_data   = EMPTY;
        status_next = ST_OK;
        unique case (func_reg)
            FN_INSERT:
            begin
                if (!reserved && !hit_reg)
                begin
                    if (empty_reg)
                    begin
                        do_write  = 1'b1;
                        slot_addr = empty_idx_reg;
                        slot_data = key_reg;
                    end
                    else
                    begin
                        status_next = ST_FULL;
                    end
                end
            end
            FN_DELETE:
            begin
                do_write = !reserved && hit_reg;
            end
            FN_FIND:
            begin
                if (reserved || !hit_reg)
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        mem_ctl.wr_en = 1'b0;
        mem_ctl.rd_en = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = EMPTY;
        rd_addr       = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
            end
            S_IDLE:
            begin
                mem_ctl.rd_en = accept;
            end
            S_SCAN:
            begin
                mem_ctl.rd_en = (idx_reg != LAST_IDX);
                rd_addr       = idx_reg + AW'(1);
            end
            S_DONE:
            begin
                mem_ctl.wr_en = do_write;
                wr_addr       = slot_addr;
                wr_data       = slot_data;
            end
            default:
            begin
                mem_ctl.wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            empty_reg     <= 1'b0;
            done_reg      <= 1'b0;
            status_reg    <= ST_OK;
            hit_idx_reg   <= '0;
            empty_idx_reg <= '0;
            func_reg      <= FN_INSERT;
            key_reg       <= '0;
        end
        else
        begin
            done_reg <= (state_reg == S_DONE);
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_IDLE;
                    end
                    idx_reg <= idx_reg + AW'(1);
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg  <= func_t'(func);
                        key_reg   <= TOPIC_BITS'(topic);
                        idx_reg   <= '0;
                        hit_reg   <= 1'b0;
                        empty_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (!hit_reg && (rd_data == key_reg))
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= idx_reg;
                    end
                    if (!empty_reg && (rd_data == EMPTY))
                    begin
                        empty_reg     <= 1'b1;
                        empty_idx_reg <= idx_reg;
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                S_DONE:
                begin
                    status_reg <= status_next;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_SCAN) && (idx_reg == '0) && !hit_reg && !empty_reg)
        else $error("accepted request did not start a scan from slot zero");

    a_done_follows_decision: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |=> done_reg && (state_reg == S_IDLE))
        else $error("result strobe missing after decision");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for more than one cycle");

    a_hit_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (hit_reg && (state_reg == S_SCAN)) |=> hit_reg && $stable(hit_idx_reg))
        else $error("first match lost during scan");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) || (state_reg == S_IDLE)) |-> !mem_ctl.wr_en)
        else $error("slot write overlaps a scan");

endmodule

FILE: sv/subscription_set_table_unit.sv
// Top level of the subscription set table: sequencer plus slot memory.
//
// Each request scans every slot once, one slot per cycle through the memory's
// single read port, then decides and writes back at most one slot. Done rises
// with the status of the request in the same cycle that busy falls, and a new
// request is taken only once busy is low, so requests do not overlap. After
// reset the block sweeps all slots to empty, one slot per cycle, holding busy
// high until the sweep ends and only then taking the first request. The status
// strobe cannot be held off: capture status in the cycle done is high.
module subscription_set_table_unit
    import sst_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int TOPIC_BITS = TOPIC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [FUNC_W-1:0]     func,
    input  logic [TOPIC_IN_W-1:0] topic,
    output logic                  busy,
    output logic                  done,
    output logic [STATUS_W-1:0]   status
);

    localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    mem_ctl_t              mem_ctl;
    logic [AW-1:0]         wr_addr;
    logic [TOPIC_BITS-1:0] wr_data;
    logic [AW-1:0]         rd_addr;
    logic [TOPIC_BITS-1:0] rd_data;

    sst_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .TOPIC_BITS (TOPIC_BITS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .func    (func),
        .topic   (topic),
        .busy    (busy),
        .done    (done),
        .status  (status),
        .mem_ctl (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sst_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .TOPIC_BITS (TOPIC_BITS)
    ) u_mem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
